// ===== rtl/shift_interval_word_reader_core_defines.svh =====
// Assertion macros shared by the shift interval word reader RTL.
`ifndef SHIFT_INTERVAL_WORD_READER_CORE_DEFINES_SVH
`define SHIFT_INTERVAL_WORD_READER_CORE_DEFINES_SVH

// Clocked check, disabled while reset is held.
`define SIWR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the core's own clock and reset.
`define SIWR_CHECK(label, prop, msg) \
    `SIWR_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/siwr_pkg.sv =====
// Shared types, codes and constants for the shift interval word reader.
package siwr_pkg;

    localparam int WORD_BITS     = 32;
    localparam int THR_BITS      = 10;
    localparam int PIN_BITS      = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;
    localparam int PORT_BITS_DEF   = 8;

    localparam logic [THR_BITS-1:0]  THR_RESET   = 10'd512;
    localparam logic [WORD_BITS-1:0] DELTA_RESET = 32'd1;
    localparam logic [PIN_BITS-1:0]  PIN_RESET   = 8'hFF;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAKE   = 1'b1;

    localparam logic MODE_ANALOG  = 1'b0;
    localparam logic MODE_DIGITAL = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INPUT_MODE = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_MSG_DELTA  = 2'd2,
        CFG_PIN_MASK   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_LISTEN  = 2'd0,
        PH_MEASURE = 2'd1,
        PH_READY   = 2'd2,
        PH_TAKEN   = 2'd3
    } t_phase;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_DIV  = 1'b1
    } t_ctl_state;

endpackage

// ===== rtl/shift_interval_word_reader_core.sv =====
// Shift interval word reader: shift detection, phase tracking and bit-serial interval divider.
//
// The core watches timestamped samples for shifts (analog: absolute change from the
// previous sample of at least the threshold; digital: the masked port bits toggle between
// zero and nonzero) and measures the time between two shifts. The wrapped interval is
// divided by msg_delta in a restoring divider that retires one quotient bit per cycle
// until all TIME_BITS interval bits are through; every other item (take, listening,
// ready/taken reset, measuring without a shift) is finished in the idle state. One item
// is in flight at a time and each yields exactly one word on the output channel:
// word_ready (phase is ready after the item), word (last measured word) and shift_seen.
// A new item is taken once the core is idle and the result register is free or being
// drained in the same cycle. Configuration writes are only legal while the core is idle.
`include "shift_interval_word_reader_core_defines.svh"

module shift_interval_word_reader_core #(
    parameter int SAMPLE_BITS = siwr_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = siwr_pkg::TIME_BITS_DEF,
    parameter int PORT_BITS   = siwr_pkg::PORT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [siwr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [siwr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_in_action,
    input  logic [TIME_BITS-1:0]                i_in_now,
    input  logic [SAMPLE_BITS-1:0]              i_in_sample,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_out_word_ready,
    output logic [siwr_pkg::WORD_BITS-1:0]      o_out_word,
    output logic                                o_out_shift_seen
);

    localparam int WB = siwr_pkg::WORD_BITS;
    localparam int TB = siwr_pkg::THR_BITS;
    // previous value holds an analog reading, a masked port level, or the threshold reset
    localparam int PB0       = (SAMPLE_BITS > PORT_BITS) ? SAMPLE_BITS : PORT_BITS;
    localparam int PREV_BITS = (PB0 > TB) ? PB0 : TB;
    localparam int CNT_BITS  = $clog2(TIME_BITS);

    // ---------------- configuration registers ----------------
    logic                                r_mode;
    logic [TB-1:0]                       r_thr;
    logic [WB-1:0]                       r_delta;
    logic [siwr_pkg::PIN_BITS-1:0]       r_pin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= siwr_pkg::MODE_ANALOG;
            r_thr   <= siwr_pkg::THR_RESET;
            r_delta <= siwr_pkg::DELTA_RESET;
            r_pin   <= siwr_pkg::PIN_RESET;
        end else if (i_cfg_we) begin
            unique case (siwr_pkg::t_cfg_reg'(i_cfg_idx))
                siwr_pkg::CFG_INPUT_MODE: r_mode <= i_cfg_data[0];
                siwr_pkg::CFG_THRESHOLD:  r_thr  <= i_cfg_data[TB-1:0];
                siwr_pkg::CFG_MSG_DELTA: begin
                    // zero divisor is stored as one
                    r_delta <= (i_cfg_data[WB-1:0] == '0) ? siwr_pkg::DELTA_RESET
                                                          : i_cfg_data[WB-1:0];
                end
                siwr_pkg::CFG_PIN_MASK:   r_pin  <= i_cfg_data[siwr_pkg::PIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    siwr_pkg::t_ctl_state  r_state, n_state;
    siwr_pkg::t_phase      r_phase, n_phase;
    logic [PREV_BITS-1:0]  r_prev, n_prev;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic [WB-1:0]         r_last, n_last;
    logic                  r_ovalid, n_ovalid;
    logic                  r_oshift, n_oshift;

    // divider: dividend shifts out MSB first, quotient shifts in at the LSB
    logic [TIME_BITS-1:0]  r_dvd, n_dvd;
    logic [WB-1:0]         r_rem, n_rem;
    logic [WB-1:0]         r_quo, n_quo;
    logic                  r_sat, n_sat;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;

    // ---------------- shift detection ----------------
    logic                  w_acc;
    logic [PREV_BITS-1:0]  w_cur_ana, w_cur_dig, w_diff;
    logic                  w_shift;
    logic [WB:0]           w_rem_sh;
    logic                  w_qbit;
    logic [WB-1:0]         w_word;

    assign o_in_stall = !((r_state == siwr_pkg::CTL_IDLE) && (!r_ovalid || !i_out_stall));
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        w_cur_ana = PREV_BITS'(i_in_sample);
        w_cur_dig = PREV_BITS'(i_in_sample) & PREV_BITS'({PORT_BITS{1'b1}})
                  & PREV_BITS'(r_pin);
        w_diff    = (w_cur_ana >= r_prev) ? (w_cur_ana - r_prev) : (r_prev - w_cur_ana);
        if (r_mode == siwr_pkg::MODE_DIGITAL) begin
            w_shift = (w_cur_dig != '0) != (r_prev != '0);
        end else begin
            w_shift = w_diff >= PREV_BITS'(r_thr);
        end
    end

    // one restoring step per cycle
    assign w_rem_sh = {r_rem, r_dvd[TIME_BITS-1]};
    assign w_qbit   = w_rem_sh >= {1'b0, r_delta};

    // ---------------- next state ----------------
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_start  = r_start;
        n_last   = r_last;
        n_ovalid = r_ovalid;
        n_oshift = r_oshift;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_sat    = r_sat;
        n_cnt    = r_cnt;
        w_word   = '0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            siwr_pkg::CTL_IDLE: begin
                if (w_acc) begin
                    if (i_in_action == siwr_pkg::ACT_TAKE) begin
                        n_phase  = siwr_pkg::PH_TAKEN;
                        n_oshift = 1'b0;
                        n_ovalid = 1'b1;
                    end else begin
                        n_prev   = (r_mode == siwr_pkg::MODE_DIGITAL) ? w_cur_dig : w_cur_ana;
                        n_oshift = w_shift;
                        unique case (r_phase)
                            siwr_pkg::PH_LISTEN: begin
                                if (w_shift) begin
                                    n_start = i_in_now;
                                    n_phase = siwr_pkg::PH_MEASURE;
                                end
                                n_ovalid = 1'b1;
                            end
                            siwr_pkg::PH_MEASURE: begin
                                if (w_shift) begin
                                    n_dvd   = i_in_now - r_start;   // wraps
                                    n_rem   = '0;
                                    n_quo   = '0;
                                    n_sat   = 1'b0;
                                    n_cnt   = CNT_BITS'(TIME_BITS - 1);
                                    n_state = siwr_pkg::CTL_DIV;
                                end else begin
                                    n_ovalid = 1'b1;
                                end
                            end
                            default: begin
                                // ready or taken: any sample re-arms
                                n_phase  = siwr_pkg::PH_LISTEN;
                                n_ovalid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            siwr_pkg::CTL_DIV: begin
                n_dvd = {r_dvd[TIME_BITS-2:0], 1'b0};
                n_rem = w_qbit ? WB'(w_rem_sh - {1'b0, r_delta}) : w_rem_sh[WB-1:0];
                n_quo = {r_quo[WB-2:0], w_qbit};
                // a bit leaving the top means the quotient exceeds the word
                n_sat = r_sat | r_quo[WB-1];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    w_word   = n_sat ? {WB{1'b1}} : n_quo;
                    n_last   = w_word;
                    // digital mode waits for a nonzero word
                    if (r_mode == siwr_pkg::MODE_ANALOG || w_word != '0) begin
                        n_phase = siwr_pkg::PH_READY;
                    end
                    n_ovalid = 1'b1;
                    n_state  = siwr_pkg::CTL_IDLE;
                end
            end
            default: n_state = siwr_pkg::CTL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= siwr_pkg::CTL_IDLE;
            r_phase  <= siwr_pkg::PH_LISTEN;
            r_prev   <= PREV_BITS'(siwr_pkg::THR_RESET);
            r_start  <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_start  <= n_start;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_oshift <= n_oshift;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_sat    <= n_sat;
        r_cnt    <= n_cnt;
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_word_ready = (r_phase == siwr_pkg::PH_READY);
    assign o_out_word       = r_last;
    assign o_out_shift_seen = r_oshift;

    // ---------------- assertions ----------------
    `SIWR_CHECK(a_no_accept_over_held_word,
        (r_ovalid && i_out_stall) |-> o_in_stall,
        "item accepted while a result is held")
    `SIWR_CHECK(a_div_finishes_with_word,
        (r_state == siwr_pkg::CTL_DIV && r_cnt == '0) |=>
            (r_state == siwr_pkg::CTL_IDLE && o_out_valid),
        "divider finished without a result")
    `SIWR_CHECK(a_take_reports_no_shift,
        (w_acc && i_in_action == siwr_pkg::ACT_TAKE) |=>
            (o_out_valid && !o_out_shift_seen && r_phase == siwr_pkg::PH_TAKEN),
        "take item did not produce a taken result")
    `SIWR_CHECK(a_div_blocks_input,
        (r_state == siwr_pkg::CTL_DIV) |-> (o_in_stall && !r_ovalid),
        "input open or result pending during division")

endmodule
